### design/hqt_pkg.sv
// Package for the hysteresis threshold unit: state encoding, request/result
// and configuration types, register indexes and reset values.
// No dependencies.
package hqt_pkg;

   typedef enum logic [1:0] {
      ST_OFF_STABLE  = 2'd0,
      ST_OFF_PENDING = 2'd1,
      ST_ON_STABLE   = 2'd2,
      ST_ON_PENDING  = 2'd3
   } state_type;

   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ON_THRESHOLD  = 3'd0,
      CSR_OFF_THRESHOLD = 3'd1,
      CSR_ON_HOLD_MS    = 3'd2,
      CSR_OFF_HOLD_MS   = 3'd3,
      CSR_KEEP_ALIVE_MS = 3'd4,
      CSR_FORCE_REPORT  = 3'd5
   } csr_index_type;

   // 0.1 in Q16.16, rounded to nearest
   localparam logic signed [31:0] THRESHOLD_RESET  = 32'sd6554;
   localparam logic [31:0]        KEEP_ALIVE_RESET = 32'd1800000;

   typedef struct packed {
      logic signed [31:0] on_threshold;
      logic signed [31:0] off_threshold;
      logic [31:0]        on_hold_ms;
      logic [31:0]        off_hold_ms;
      logic [31:0]        keep_alive_ms;
      logic               force_report;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic [31:0]        now_ms;
      logic               first_sample;
      logic [31:0]        last_report_ms;
      logic               ever_reported;
   } req_type;

   typedef struct packed {
      logic       is_on;
      logic [1:0] state_code;
      logic       report_due;
   } rsp_type;

endpackage

### design/hqt_csr.sv
// Configuration register file for the hysteresis threshold unit.
// Depends on hqt_pkg.
module hqt_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hqt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_data,
   output hqt_pkg::cfg_type               cfg
);
   import hqt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index)
            CSR_ON_THRESHOLD:  cfg_in.on_threshold  = csr_data;
            CSR_OFF_THRESHOLD: cfg_in.off_threshold = csr_data;
            CSR_ON_HOLD_MS:    cfg_in.on_hold_ms    = csr_data;
            CSR_OFF_HOLD_MS:   cfg_in.off_hold_ms   = csr_data;
            CSR_KEEP_ALIVE_MS: cfg_in.keep_alive_ms = csr_data;
            CSR_FORCE_REPORT:  cfg_in.force_report  = csr_data[0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_threshold  <= THRESHOLD_RESET;
         cfg_ff.off_threshold <= THRESHOLD_RESET;
         cfg_ff.on_hold_ms    <= '0;
         cfg_ff.off_hold_ms   <= '0;
         cfg_ff.keep_alive_ms <= KEEP_ALIVE_RESET;
         cfg_ff.force_report  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/hqt_core.sv
// On/off state machine with hold-time qualification and report decision.
// Holds the state and the two pending start times. Depends on hqt_pkg.
module hqt_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_valid,
   input  hqt_pkg::req_type  req,
   input  hqt_pkg::cfg_type  cfg,
   output hqt_pkg::rsp_type  rsp
);
   import hqt_pkg::*;

   state_type   state_ff, state_in;
   logic [31:0] on_start_ff, on_start_in;
   logic [31:0] off_start_ff, off_start_in;

   logic        above_on, below_off;
   logic        on_expired, off_expired;
   logic        keep_alive_due;
   logic        confirmed;
   logic [31:0] on_elapsed, off_elapsed, report_age;

   assign above_on    = $signed(req.sample_value) > $signed(cfg.on_threshold);
   assign below_off   = $signed(req.sample_value) < $signed(cfg.off_threshold);
   assign on_elapsed  = req.now_ms - on_start_ff;
   assign off_elapsed = req.now_ms - off_start_ff;
   assign report_age  = req.now_ms - req.last_report_ms;
   assign on_expired  = on_elapsed > cfg.on_hold_ms;
   assign off_expired = off_elapsed > cfg.off_hold_ms;

   // next state
   always_comb begin
      state_in     = state_ff;
      on_start_in  = on_start_ff;
      off_start_in = off_start_ff;
      if (req.first_sample) begin
         on_start_in  = '0;
         off_start_in = '0;
         state_in     = below_off ? ST_OFF_STABLE : ST_ON_STABLE;
      end else begin
         unique case (state_ff)
            ST_OFF_STABLE: begin
               if (above_on) begin
                  if (cfg.on_hold_ms != '0) begin
                     on_start_in = req.now_ms;
                     state_in    = ST_OFF_PENDING;
                  end else begin
                     state_in = ST_ON_STABLE;
                  end
               end
            end
            ST_OFF_PENDING: begin
               if (!above_on) begin
                  state_in = ST_OFF_STABLE;
               end else if (on_expired) begin
                  state_in = ST_ON_STABLE;
               end
            end
            ST_ON_STABLE: begin
               if (below_off) begin
                  if (cfg.off_hold_ms != '0) begin
                     off_start_in = req.now_ms;
                     state_in     = ST_ON_PENDING;
                  end else begin
                     state_in = ST_OFF_STABLE;
                  end
               end
            end
            ST_ON_PENDING: begin
               if (!below_off) begin
                  state_in = ST_ON_STABLE;
               end else if (off_expired) begin
                  state_in = ST_OFF_STABLE;
               end
            end
            default: state_in = ST_OFF_STABLE;
         endcase
      end
   end

   // outputs: a confirmed change crosses to the stable state of the other side
   always_comb begin
      keep_alive_due = report_age >= cfg.keep_alive_ms;
      confirmed      = !req.first_sample &&
                       ((!state_ff[1] && state_in == ST_ON_STABLE) ||
                        (state_ff[1] && state_in == ST_OFF_STABLE));
      rsp.is_on      = state_in[1];
      rsp.state_code = state_in;
      rsp.report_due = cfg.force_report | ~req.ever_reported | keep_alive_due | confirmed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_OFF_STABLE;
         on_start_ff  <= '0;
         off_start_ff <= '0;
      end else if (step_valid) begin
         state_ff     <= state_in;
         on_start_ff  <= on_start_in;
         off_start_ff <= off_start_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step_valid |=> $stable(state_ff) && $stable(on_start_ff) && $stable(off_start_ff))
      else $error("state changed without a request");

   a_first_init: assert property (@(posedge clock) disable iff (reset)
      step_valid && req.first_sample |=>
         (state_ff == ST_ON_STABLE || state_ff == ST_OFF_STABLE) &&
         on_start_ff == '0 && off_start_ff == '0)
      else $error("first sample did not initialize state");

   a_on_start_capture: assert property (@(posedge clock) disable iff (reset)
      step_valid && !req.first_sample && state_ff == ST_OFF_STABLE &&
      state_in == ST_OFF_PENDING |=> on_start_ff == $past(req.now_ms))
      else $error("on start time not captured");

   a_confirm_reports: assert property (@(posedge clock) disable iff (reset)
      step_valid && !req.first_sample && state_ff == ST_ON_PENDING &&
      state_in == ST_OFF_STABLE |-> rsp.report_due)
      else $error("confirmed off without report");
`endif

endmodule

### design/hysteresis_qualified_threshold_fsm_unit.sv
// Hysteresis threshold classifier with hold-time qualification, top level.
// A request passes through the input register, then the state update writes
// the result register. Throughput: one request per cycle unless rsp_stall
// holds a valid result; the result register backs up the input register under rsp_stall.
// Synchronous active-high reset clears both valid flags, the state
// (off-stable, start times zero) and loads register defaults.
module hysteresis_qualified_threshold_fsm_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [31:0]            req_sample_value,
   input  logic [31:0]                   req_now_ms,
   input  logic                          req_first_sample,
   input  logic [31:0]                   req_last_report_ms,
   input  logic                          req_ever_reported,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_on,
   output logic [1:0]                    rsp_state_code,
   output logic                          rsp_report_due,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hqt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import hqt_pkg::*;

   cfg_type cfg;
   req_type req_ff;
   rsp_type rsp_ff, rsp_calc;
   logic    in_vld_ff, in_vld_in;
   logic    out_vld_ff, out_vld_in;
   logic    accept, advance;

   assign advance   = in_vld_ff & (~out_vld_ff | ~rsp_stall);
   assign req_stall = in_vld_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign in_vld_in  = accept | (in_vld_ff & ~advance);
   assign out_vld_in = advance | (out_vld_ff & rsp_stall);

   hqt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hqt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .req        (req_ff),
      .cfg        (cfg),
      .rsp        (rsp_calc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.sample_value   <= req_sample_value;
         req_ff.now_ms         <= req_now_ms;
         req_ff.first_sample   <= req_first_sample;
         req_ff.last_report_ms <= req_last_report_ms;
         req_ff.ever_reported  <= req_ever_reported;
      end
      if (advance) begin
         rsp_ff <= rsp_calc;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_is_on      = rsp_ff.is_on;
   assign rsp_state_code = rsp_ff.state_code;
   assign rsp_report_due = rsp_ff.report_due;

endmodule
